FILE: hdl/ltc_timecode_frame_encoder_top_macros.svh
// Assertion macros for the LTC timecode frame encoder.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef LTC_TIMECODE_FRAME_ENCODER_TOP_MACROS_SVH
`define LTC_TIMECODE_FRAME_ENCODER_TOP_MACROS_SVH
`ifndef SYNTH
// Checked only outside reset.
`define LTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, during reset as well.
`define LTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTC_ASSERT(lbl, prop, msg)
`define LTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/ltc_pkg.sv
// Shared constants and helper functions for the LTC timecode frame encoder.
// Used by ltc_frame_builder and ltc_timecode_frame_encoder_top; no dependencies.
package ltc_pkg;

  localparam int unsigned DATA_BITS = 64;
  localparam int unsigned HALF_BITS = 160;
  localparam logic [7:0] HALF_LAST  = 8'd159;
  localparam logic [15:0] SYNC_WORD = 16'hBFFC;

  localparam logic [5:0] FRAME_MAX  = 6'd29;
  localparam logic [5:0] SECOND_MAX = 6'd59;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [5:0] HOUR_MAX   = 6'd23;

  localparam logic [1:0] RATE_EBU_25 = 2'd1;
  localparam logic [1:0] RATE_DROP   = 2'd2;

  localparam int unsigned DROP_BIT   = 10;
  localparam int unsigned EXT_BIT    = 58;
  localparam int unsigned POL_BIT    = 27;
  localparam int unsigned POL_BIT_25 = 59;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Saturates v at top and splits it into {tens, units}; values never exceed 59.
  function automatic logic [7:0] sat_bcd(input logic [5:0] v, input logic [5:0] top);
    logic [5:0] s;
    logic [3:0] tens;
    logic [5:0] units;
    s = (v > top) ? top : v;
    if (s >= 6'd50)      tens = 4'd5;
    else if (s >= 6'd40) tens = 4'd4;
    else if (s >= 6'd30) tens = 4'd3;
    else if (s >= 6'd20) tens = 4'd2;
    else if (s >= 6'd10) tens = 4'd1;
    else                 tens = 4'd0;
    units = s - 6'({tens, 3'b000} + {1'b0, tens, 1'b0});
    return {tens, units[3:0]};
  endfunction

endpackage

FILE: hdl/ltc_timecode_frame_encoder_top.sv
// LTC timecode frame encoder, top level: input/output streams, shift chain, line coder.
// Depends on ltc_pkg, ltc_bit_cell, ltc_frame_builder and the assertion macro header.
//
// Usage: each input transaction is either a load (in_tuser = 0), which builds a new
// frame from the time fields and holds it as pending, or a tick (in_tuser = 1), which
// emits one half-bit of the biphase-mark line signal on the output stream. A load
// gives no output transaction; a tick gives exactly one. The pending frame is taken
// into the 64-cell shift chain on the tick that starts a frame, so a load never
// changes the frame in progress. The chain advances one cell per bit, the last
// sixteen bits come from the fixed sync word.
// A tick's result is presented in the cycle after its acceptance, from an
// output register. Throughput: one transaction per cycle, set by the line coder and
// chain shift; a result waiting in the output register does not stop
// the next transaction from being accepted when the receiver takes it in that cycle.
// When the receiver stalls, the output register holds its result and in_tready falls.
// Reset clears the pending frame to all zero, the half-bit position to the start of
// a frame, the line level to low and external_clock to 0; the block is ready at once.
// The configuration register is written through cfg_valid/cfg_ready, always ready.
`include "ltc_timecode_frame_encoder_top_macros.svh"

module ltc_timecode_frame_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_number[4:0], second_number[10:5], minute_number[16:11], hour_number[21:17],
  // rate_type[23:22]
  input  logic [23:0] in_tdata,
  // operation[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // line_level[0], zero padding [7:1]
  output logic [7:0]  out_tdata,
  // frame_start[0]
  output logic [0:0]  out_tuser,
  // frame_end
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  // external_clock[0]
  input  logic [0:0]  cfg_data
);

  logic        ext_clock_r;
  logic        ext_clock_nxt;
  logic [7:0]  half_pos_r;
  logic [7:0]  half_pos_nxt;
  logic        level_r;
  logic        level_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_level_r;
  logic        out_start_r;
  logic        out_end_r;
  logic        in_acc;
  logic        load_acc;
  logic        tick_acc;
  logic        at_start;
  logic        odd_half;
  logic [6:0]  bit_idx;
  logic        cur_bit;
  logic        chain_load;
  logic        chain_shift;
  logic [63:0] pending_bits;
  logic [63:0] cell_q;

  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser[0] == ltc_pkg::OP_LOAD);
  assign tick_acc  = in_acc && (in_tuser[0] == ltc_pkg::OP_TICK);

  ltc_frame_builder u_builder (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_en       (load_acc),
    .ext_clock     (ext_clock_r),
    .frame_number  (in_tdata[4:0]),
    .second_number (in_tdata[10:5]),
    .minute_number (in_tdata[16:11]),
    .hour_number   (in_tdata[21:17]),
    .rate_type     (in_tdata[23:22]),
    .pending_bits  (pending_bits)
  );

  assign at_start    = (half_pos_r == 8'd0);
  assign odd_half    = half_pos_r[0];
  assign bit_idx     = half_pos_r[7:1];
  assign chain_load  = tick_acc && at_start;
  // The chain moves on once the second half of a data bit has been sent.
  assign chain_shift = tick_acc && odd_half && !bit_idx[6];

  genvar gi;
  generate
    for (gi = 0; gi < ltc_pkg::DATA_BITS; gi++) begin : g_cell
      logic nbr;
      if (gi == ltc_pkg::DATA_BITS - 1) begin : g_end
        assign nbr = 1'b0;
      end else begin : g_mid
        assign nbr = cell_q[gi + 1];
      end
      ltc_bit_cell u_cell (
        .clk      (clk),
        .load_en  (chain_load),
        .load_bit (pending_bits[gi]),
        .shift_en (chain_shift),
        .shift_in (nbr),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  assign cur_bit = bit_idx[6] ? ltc_pkg::SYNC_WORD[bit_idx[3:0]] : cell_q[0];

  always_comb begin
    ext_clock_nxt = ext_clock_r;
    if (cfg_valid && cfg_ready) begin
      ext_clock_nxt = cfg_data[0];
    end

    half_pos_nxt = half_pos_r;
    level_nxt    = level_r;
    if (tick_acc) begin
      if (!odd_half) begin
        level_nxt = at_start ? 1'b1 : !level_r;
      end else begin
        level_nxt = cur_bit ? !level_r : level_r;
      end
      half_pos_nxt = (half_pos_r == ltc_pkg::HALF_LAST) ? 8'd0 : half_pos_r + 8'd1;
    end

    out_valid_nxt = out_valid_r;
    if (tick_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_clock_r <= 1'b0;
      half_pos_r  <= 8'd0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ext_clock_r <= ext_clock_nxt;
      half_pos_r  <= half_pos_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_level_r <= level_nxt;
      out_start_r <= at_start;
      out_end_r   <= (half_pos_r == ltc_pkg::HALF_LAST);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'd0, out_level_r};
  assign out_tuser[0] = out_start_r;
  assign out_tlast    = out_end_r;

  `LTC_ASSERT(a_pos_range, half_pos_r < 8'(ltc_pkg::HALF_BITS), "half-bit position out of range")
  `LTC_ASSERT(a_start_high, (out_valid_r && out_start_r) |-> out_level_r, "frame does not start high")
  `LTC_ASSERT(a_last_flag, (tick_acc && half_pos_r == ltc_pkg::HALF_LAST) |=> (out_valid_r && out_end_r && half_pos_r == 8'd0), "frame end not flagged")
  `LTC_ASSERT(a_load_silent, (load_acc && !out_valid_r) |=> !out_valid_r, "load produced an output")
  `LTC_ASSERT(a_stall_hold, (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_level_r) && $stable(half_pos_r)), "stalled result or position changed")

endmodule

FILE: hdl/ltc_bit_cell.sv
// One cell of the active frame shift chain: holds one data bit.
// Standalone; instantiated as a row by ltc_timecode_frame_encoder_top.
module ltc_bit_cell (
  input  logic clk,
  input  logic load_en,
  input  logic load_bit,
  input  logic shift_en,
  input  logic shift_in,
  output logic q
);

  logic bit_r;
  logic bit_nxt;

  always_comb begin
    bit_nxt = bit_r;
    if (load_en) begin
      bit_nxt = load_bit;
    end else if (shift_en) begin
      bit_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign q = bit_r;

endmodule

FILE: hdl/ltc_frame_builder.sv
// Builds data bits 0..63 of an LTC frame from a load transaction and holds them as pending.
// Depends on ltc_pkg.
module ltc_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_en,
  input  logic        ext_clock,
  input  logic [4:0]  frame_number,
  input  logic [5:0]  second_number,
  input  logic [5:0]  minute_number,
  input  logic [4:0]  hour_number,
  input  logic [1:0]  rate_type,
  output logic [63:0] pending_bits
);

  logic [63:0] pending_r;
  logic [63:0] pending_nxt;
  logic [63:0] base;
  logic [7:0]  fr_bcd;
  logic [7:0]  se_bcd;
  logic [7:0]  mi_bcd;
  logic [7:0]  hr_bcd;
  logic        need_pol;

  always_comb begin
    fr_bcd = ltc_pkg::sat_bcd({1'b0, frame_number}, ltc_pkg::FRAME_MAX);
    se_bcd = ltc_pkg::sat_bcd(second_number, ltc_pkg::SECOND_MAX);
    mi_bcd = ltc_pkg::sat_bcd(minute_number, ltc_pkg::MINUTE_MAX);
    hr_bcd = ltc_pkg::sat_bcd({1'b0, hour_number}, ltc_pkg::HOUR_MAX);

    base = '0;
    base[3:0]   = fr_bcd[3:0];
    base[9:8]   = fr_bcd[5:4];
    base[19:16] = se_bcd[3:0];
    base[26:24] = se_bcd[6:4];
    base[35:32] = mi_bcd[3:0];
    base[42:40] = mi_bcd[6:4];
    base[51:48] = hr_bcd[3:0];
    base[57:56] = hr_bcd[5:4];
    base[ltc_pkg::DROP_BIT] = (rate_type == ltc_pkg::RATE_DROP);
    base[ltc_pkg::EXT_BIT]  = ext_clock;

    // The sync word holds an odd number of ones, so the data must too.
    need_pol = ~^base;
    pending_nxt = base;
    if (rate_type == ltc_pkg::RATE_EBU_25) begin
      pending_nxt[ltc_pkg::POL_BIT_25] = need_pol;
    end else begin
      pending_nxt[ltc_pkg::POL_BIT] = need_pol;
    end
    if (!load_en) begin
      pending_nxt = pending_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  assign pending_bits = pending_r;

endmodule

FILE: sim/tb_ltc_timecode_frame_encoder_top.sv
// Self-checking testbench for ltc_timecode_frame_encoder_top: drives loads and half-bit
// ticks, predicts the biphase-mark line levels and frame markers, and checks each result.
// Depends on ltc_pkg and the encoder RTL.
module tb_ltc_timecode_frame_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RATE_FILM_24  = 2'd0;
  localparam logic [1:0] RATE_SMPTE_30 = 2'd3;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 30;

  typedef struct packed {
    logic       op;
    logic [4:0] frame_no;
    logic [5:0] second_no;
    logic [5:0] minute_no;
    logic [4:0] hour_no;
    logic [1:0] rate;
  } tc_item_t;

  typedef struct packed {
    logic line_level;
    logic frame_start;
    logic frame_end;
  } half_bit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;

  // Encoder state as the testbench sees it.
  logic        ext_clock = 1'b0;
  logic [63:0] pending_word = '0;
  logic [63:0] live_word = '0;
  logic [7:0]  half_pos = '0;
  logic        line_lvl = 1'b0;

  tc_item_t    tc_items_todo[$];
  half_bit_t   levels_due[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned stim_pos = 0;
  int unsigned loads_seen = 0;
  int unsigned ticks_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;
  bit          in_took = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;

  ltc_timecode_frame_encoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bits 0..63 of the frame: BCD time digits, flags and the parity-balancing bit.
  function automatic logic [63:0] build_timecode_word(input logic [4:0] frame_no,
                                                      input logic [5:0] second_no,
                                                      input logic [5:0] minute_no,
                                                      input logic [4:0] hour_no,
                                                      input logic [1:0] rate);
    int unsigned f, s, m, h, pol;
    logic [63:0] w;
    f = (frame_no > ltc_pkg::FRAME_MAX) ? ltc_pkg::FRAME_MAX : frame_no;
    s = (second_no > ltc_pkg::SECOND_MAX) ? ltc_pkg::SECOND_MAX : second_no;
    m = (minute_no > ltc_pkg::MINUTE_MAX) ? ltc_pkg::MINUTE_MAX : minute_no;
    h = (hour_no > ltc_pkg::HOUR_MAX) ? ltc_pkg::HOUR_MAX : hour_no;
    w = '0;
    w[3:0]   = 4'(f % 10);
    w[9:8]   = 2'(f / 10);
    w[19:16] = 4'(s % 10);
    w[26:24] = 3'(s / 10);
    w[35:32] = 4'(m % 10);
    w[42:40] = 3'(m / 10);
    w[51:48] = 4'(h % 10);
    w[57:56] = 2'(h / 10);
    if (rate == ltc_pkg::RATE_DROP) w[ltc_pkg::DROP_BIT] = 1'b1;
    if (ext_clock) w[ltc_pkg::EXT_BIT] = 1'b1;
    pol = (rate == ltc_pkg::RATE_EBU_25) ? ltc_pkg::POL_BIT_25 : ltc_pkg::POL_BIT;
    // The sync word holds an odd number of ones, so the data must too.
    if (!(^w)) w[pol] = 1'b1;
    return w;
  endfunction

  function automatic half_bit_t next_half_bit();
    half_bit_t   hb;
    int unsigned bit_no;
    logic        bit_val;
    if (half_pos == 0) live_word = pending_word;
    bit_no = half_pos >> 1;
    if (!half_pos[0]) begin
      line_lvl = (half_pos == 0) ? 1'b1 : ~line_lvl;
    end else begin
      bit_val = (bit_no < 64) ? live_word[bit_no] : ltc_pkg::SYNC_WORD[bit_no - 64];
      line_lvl = line_lvl ^ bit_val;
    end
    hb.line_level  = line_lvl;
    hb.frame_start = (half_pos == 0);
    hb.frame_end   = (half_pos == ltc_pkg::HALF_LAST);
    half_pos = (half_pos == ltc_pkg::HALF_LAST) ? 8'd0 : half_pos + 8'd1;
    return hb;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    tc_item_t item;
    logic     nvalid;
    nvalid = in_tvalid && !in_took;
    if (rst_n && !nvalid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (tc_items_todo.size() > 0) begin
        item = tc_items_todo.pop_front();
        nvalid = 1'b1;
        in_tdata <= {item.rate, item.hour_no, item.minute_no, item.second_no, item.frame_no};
        in_tuser <= item.op;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_tvalid <= nvalid;
  end

  // Receiver: a rotating stall pattern, now and then replaced by another one.
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          stall_pat = 16'hFFFF;
        end
        1: begin
          stall_pat = 16'($urandom) | 16'h0001;
        end
        default: begin
          stall_pat = 16'hFFFF ^ (16'h0001 << $urandom_range(0, 15));
        end
      endcase
    end
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    out_tready <= stall_pat[0];
  end

  // Checks results against the oldest prediction, then predicts for newly accepted items.
  always @(posedge clk) begin
    half_bit_t want;
    if (rst_n) begin
      in_took = in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (levels_due.size() == 0) begin
          $error("unexpected result: line_level %0b, frame_start %0b, frame_end %0b",
                 out_tdata[0], out_tuser[0], out_tlast);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (out_tdata[0] !== want.line_level) begin
            $error("line_level: expected %0b, actual %0b", want.line_level, out_tdata[0]);
            mismatches++;
          end
          if (out_tuser[0] !== want.frame_start) begin
            $error("frame_start: expected %0b, actual %0b", want.frame_start, out_tuser[0]);
            mismatches++;
          end
          if (out_tlast !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, out_tlast);
            mismatches++;
          end
          if (want.frame_end) frames_seen++;
        end
      end
      if (in_took) begin
        items_taken++;
        if (in_tuser[0] == ltc_pkg::OP_LOAD) begin
          pending_word = build_timecode_word(in_tdata[4:0], in_tdata[10:5], in_tdata[16:11],
                                             in_tdata[21:17], in_tdata[23:22]);
          loads_seen++;
        end else begin
          levels_due.push_back(next_half_bit());
          ticks_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        ext_clock = cfg_data[0];
        cfg_writes++;
      end
      if (in_took || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic void queue_item(input tc_item_t item);
    tc_items_todo.push_back(item);
    items_queued++;
  endfunction

  function automatic void queue_load(input logic [4:0] frame_no, input logic [5:0] second_no,
                                     input logic [5:0] minute_no, input logic [4:0] hour_no,
                                     input logic [1:0] rate);
    queue_item('{ltc_pkg::OP_LOAD, frame_no, second_no, minute_no, hour_no, rate});
  endfunction

  // Tick data fields are ignored by the block, so they carry random bits.
  function automatic void queue_tick();
    queue_item('{ltc_pkg::OP_TICK, 5'($urandom), 6'($urandom), 6'($urandom), 5'($urandom),
                 2'($urandom)});
    stim_pos = (stim_pos + 1) % ltc_pkg::HALF_BITS;
  endfunction

  function automatic void queue_random_load();
    if ($urandom_range(0, 9) < 7) begin
      queue_load(5'($urandom_range(0, 29)), 6'($urandom_range(0, 59)),
                 6'($urandom_range(0, 59)), 5'($urandom_range(0, 23)), 2'($urandom));
    end else begin
      queue_load(5'($urandom), 6'($urandom), 6'($urandom), 5'($urandom), 2'($urandom));
    end
  endfunction

  // Ticks up to the next frame boundary, then one whole frame.
  function automatic void play_next_frame();
    while (stim_pos != 0) queue_tick();
    repeat (ltc_pkg::HALF_BITS) queue_tick();
  endfunction

  task automatic wait_idle();
    while (items_taken != items_queued || levels_due.size() != 0) @(negedge clk);
    // A trailing load gives no result, so let the block settle before returning.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ext_clock(input logic value);
    int unsigned seen;
    wait_idle();
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase_start;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    write_ext_clock(1'b0);
    // The reset frame carries all-zero data bits; loads part-way through it only take effect
    // at the next boundary, and only the later of the two.
    repeat (37) queue_tick();
    queue_load(5'd7, 6'd8, 6'd9, 5'd10, RATE_FILM_24);
    queue_load(5'd0, 6'd0, 6'd0, 5'd0, RATE_FILM_24);
    play_next_frame();
    queue_load(5'd29, 6'd59, 6'd59, 5'd23, RATE_SMPTE_30);
    play_next_frame();
    queue_load(5'd31, 6'd63, 6'd63, 5'd31, ltc_pkg::RATE_EBU_25);
    play_next_frame();
    queue_load(5'd12, 6'd34, 6'd56, 5'd19, ltc_pkg::RATE_DROP);
    play_next_frame();
    write_ext_clock(1'b1);
    queue_load(5'd29, 6'd59, 6'd59, 5'd23, ltc_pkg::RATE_EBU_25);
    play_next_frame();
    queue_load(5'd0, 6'd0, 6'd0, 5'd0, ltc_pkg::RATE_DROP);
    play_next_frame();

    // Mostly a load followed by a complete frame, mixed with short runs of noise.
    for (int ph = 0; ph < 2; ph++) begin
      write_ext_clock(ph[0]);
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 6) begin
          queue_random_load();
          play_next_frame();
        end else begin
          repeat ($urandom_range(1, 40)) begin
            if ($urandom_range(0, 4) == 0) queue_random_load();
            else queue_tick();
          end
        end
      end
    end

    wait_idle();
    repeat (6) @(negedge clk);
    if (levels_due.size() != 0) begin
      $error("%0d predicted results never arrived", levels_due.size());
      mismatches++;
    end
    $display("covered %0d loads and %0d half-bit ticks (%0d complete frames)",
             loads_seen, ticks_seen, frames_seen);
    $display("external clock flag written %0d times, %0d mismatches", cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ltc_pkg.sv
hdl/ltc_bit_cell.sv
hdl/ltc_frame_builder.sv
hdl/ltc_timecode_frame_encoder_top.sv
sim/tb_ltc_timecode_frame_encoder_top.sv
